// ===== sv/sl_pkg.sv =====
// Shared command, status and cell control definitions for the sorted list table.
`default_nettype none
package sl_pkg;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_ASC   = 3'd1;
  localparam logic [2:0] CMD_DESC  = 3'd2;
  localparam logic [2:0] CMD_DEL   = 3'd3;
  localparam logic [2:0] CMD_FIND  = 3'd4;
  localparam logic [2:0] CMD_DUMP  = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PUSH,
    OP_ASC,
    OP_DESC,
    OP_DEL,
    OP_FIND,
    OP_ROT
  } sl_op_e;

  // Broadcast to every cell for the whole command.
  typedef struct packed {
    sl_op_e op;
    logic   csign;
  } sl_bcast_t;

  // Token that walks along the chain, one cell per cycle.
  typedef struct packed {
    logic act;
    logic hit;
  } sl_tok_t;

endpackage
`default_nettype wire

// ===== sv/sl_cell.sv =====
// One slot of the list: holds a key and processes the walking token.
`default_nettype none
module sl_cell
  import sl_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32,
  parameter int IDX       = 0
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sl_bcast_t                          bcast_i,
  input  wire logic [KEY_WIDTH-1:0]               key_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]      count_i,
  input  wire sl_tok_t                            tok_i,
  input  wire logic [KEY_WIDTH-1:0]               carry_i,
  input  wire logic [KEY_WIDTH-1:0]               right_val_i,
  input  wire logic [KEY_WIDTH-1:0]               head_val_i,
  output sl_tok_t                                 tok_o,
  output logic [KEY_WIDTH-1:0]                    carry_o,
  output logic [KEY_WIDTH-1:0]                    val_o
);

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX + 1);

  logic [KEY_WIDTH-1:0] val_q, val_d;
  logic [KEY_WIDTH-1:0] carry_q, carry_d;
  sl_tok_t              tok_q, tok_d;

  logic in_list, at_end, eq, cond;

  function automatic logic key_gt(input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b,
                                  input logic s);
    logic [KEY_WIDTH-1:0] x;
    logic [KEY_WIDTH-1:0] y;
    x = a;
    y = b;
    if (s) begin
      x[KEY_WIDTH-1] = ~x[KEY_WIDTH-1];
      y[KEY_WIDTH-1] = ~y[KEY_WIDTH-1];
    end
    return x > y;
  endfunction

  assign in_list = IDX_C < count_i;
  assign at_end  = IDX_C == count_i;
  assign eq      = val_q == key_i;

  always_comb begin
    unique case (bcast_i.op)
      OP_ASC:  cond = key_gt(val_q, key_i, bcast_i.csign);
      OP_DESC: cond = key_gt(key_i, val_q, bcast_i.csign);
      default: cond = 1'b1;
    endcase
  end

  always_comb begin
    val_d   = val_q;
    carry_d = carry_i;
    tok_d   = tok_i;
    unique case (bcast_i.op)
      OP_PUSH, OP_ASC, OP_DESC: begin
        if (tok_i.act && (in_list || at_end)) begin
          if (tok_i.hit) begin
            // Already placed upstream: shift this entry one slot along.
            val_d   = carry_i;
            carry_d = val_q;
          end else if (at_end || cond) begin
            val_d     = key_i;
            carry_d   = val_q;
            tok_d.hit = 1'b1;
          end
        end
      end
      OP_DEL: begin
        if (tok_i.act && in_list) begin
          if (tok_i.hit || eq) begin
            val_d     = right_val_i;
            tok_d.hit = 1'b1;
          end
        end
      end
      OP_FIND: begin
        if (tok_i.act && in_list && eq) begin
          tok_d.hit = 1'b1;
        end
      end
      OP_ROT: begin
        // Rotate the held entries by one towards the head.
        if (IDX_N < count_i) begin
          val_d = right_val_i;
        end else if (IDX_N == count_i) begin
          val_d = head_val_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    carry_q <= carry_d;
  end

  assign tok_o   = tok_q;
  assign carry_o = carry_q;
  assign val_o   = val_q;

endmodule
`default_nettype wire

// ===== sv/sl_ctrl.sv =====
// Command sequencer: decodes commands, drives the cell chain and forms results.
`default_nettype none
module sl_ctrl
  import sl_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    command_i,
  input  wire logic [31:0]                   key_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic                               found_o,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count_o,
  output logic [31:0]                        entry_value_o,
  output logic                               last_o,
  output sl_bcast_t                          bcast_o,
  output logic [KEY_WIDTH-1:0]               key_o,
  output logic [$clog2(CAPACITY+1)-1:0]      count_o,
  output sl_tok_t                            tok_o,
  input  wire sl_tok_t                       tok_last_i,
  input  wire logic [KEY_WIDTH-1:0]          head_val_i
);

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]           state_q, state_d;
  sl_op_e               op_q, op_d;
  logic                 csign_q;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 inj_q, inj_d;
  logic [IDX_W-1:0]     dcnt_q, dcnt_d;

  logic                 done_q, done_d;
  logic [1:0]           status_q, status_d;
  logic                 found_q, found_d;
  logic [CNT_W-1:0]     ecount_q, ecount_d;
  logic [31:0]          evalue_q, evalue_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic                 full;
  logic                 dump_last;
  logic [KEY_WIDTH+31:0] key_ext;
  logic [KEY_WIDTH+31:0] head_ext;

  assign accept    = start && (state_q == ST_IDLE);
  assign full      = count_q == CAP_C;
  assign dump_last = (CNT_W'(dcnt_q) + CNT_W'(1)) == count_q;
  assign key_ext   = {{KEY_WIDTH{1'b0}}, key_value_i};
  assign head_ext  = {32'b0, head_val_i};

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    count_d  = count_q;
    inj_d    = 1'b0;
    dcnt_d   = dcnt_q;
    done_d   = 1'b0;
    status_d = STAT_OK;
    found_d  = 1'b0;
    ecount_d = count_q;
    evalue_d = '0;
    last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = key_ext[KEY_WIDTH-1:0];
          unique case (command_i)
            CMD_PUSH, CMD_ASC, CMD_DESC: begin
              if (full) begin
                done_d   = 1'b1;
                status_d = STAT_FULL;
              end else begin
                state_d = ST_SCAN;
                inj_d   = 1'b1;
                unique case (command_i)
                  CMD_PUSH: op_d = OP_PUSH;
                  CMD_ASC:  op_d = OP_ASC;
                  default:  op_d = OP_DESC;
                endcase
              end
            end
            CMD_DEL, CMD_FIND: begin
              state_d = ST_SCAN;
              inj_d   = 1'b1;
              op_d    = (command_i == CMD_DEL) ? OP_DEL : OP_FIND;
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_DUMP;
                op_d    = OP_ROT;
                dcnt_d  = '0;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The token has left the final cell: every slot has been visited.
        if (tok_last_i.act) begin
          state_d = ST_IDLE;
          op_d    = OP_IDLE;
          done_d  = 1'b1;
          unique case (op_q)
            OP_DEL: begin
              if (tok_last_i.hit) begin
                count_d = count_q - CNT_W'(1);
                found_d = 1'b1;
              end else begin
                status_d = STAT_NOTFOUND;
              end
            end
            OP_FIND: begin
              if (tok_last_i.hit) begin
                found_d = 1'b1;
              end else begin
                status_d = STAT_NOTFOUND;
              end
            end
            default: begin
              count_d = count_q + CNT_W'(1);
            end
          endcase
          ecount_d = count_d;
        end
      end
      ST_DUMP: begin
        done_d   = 1'b1;
        evalue_d = head_ext[31:0];
        last_d   = dump_last;
        dcnt_d   = dcnt_q + IDX_W'(1);
        if (dump_last) begin
          state_d = ST_IDLE;
          op_d    = OP_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        op_d    = OP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_IDLE;
      csign_q <= 1'b0;
      count_q <= '0;
      inj_q   <= 1'b0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      count_q <= count_d;
      inj_q   <= inj_d;
      dcnt_q  <= dcnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        csign_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
    ecount_q <= ecount_d;
    evalue_q <= evalue_d;
    last_q   <= last_d;
  end

  assign busy          = state_q != ST_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = ecount_q;
  assign entry_value_o = evalue_q;
  assign last_o        = last_q;
  assign bcast_o       = '{op: op_q, csign: csign_q};
  assign key_o         = key_q;
  assign count_o       = count_q;
  assign tok_o         = '{act: inj_q, hit: 1'b0};

endmodule
`default_nettype wire

// ===== sv/sorted_list_table.sv =====
// Top level of the sorted list table: sequencer plus a chain of slot cells.
//
//  channel   handshake            payload
//  command   start / busy         command_i, key_value_i
//  config    cfg_we_i             cfg_wdata_i (compare_signed)
//  result    done_o (one cycle)   status_o, found_o, entry_count_o, entry_value_o, last_o
//
// Insert, delete and contains send a token down the CAPACITY cells, one cell a cycle;
// the result is registered once the token has left the last cell.
// A dump gives one result per cycle, one for each entry, while the cells rotate once.
// A refused insert, an empty dump or an unused code answers in the following cycle.
// Reset clears the entry count and the control; slot contents are not cleared.
// Results cannot be stalled; busy stays high until the last result of a command.
`default_nettype none
module sorted_list_table
  import sl_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    command_i,
  input  wire logic [31:0]                   key_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic                               found_o,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count_o,
  output logic [31:0]                        entry_value_o,
  output logic                               last_o
);

  localparam int CNT_W = $clog2(CAPACITY+1);

  sl_bcast_t            bcast;
  logic [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]     count;
  sl_tok_t              tok   [CAPACITY+1];
  logic [KEY_WIDTH-1:0] carry [CAPACITY+1];
  logic [KEY_WIDTH-1:0] val   [CAPACITY+1];

  assign carry[0]     = '0;
  assign val[CAPACITY] = '0;

  sl_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .key_value_i   (key_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .entry_count_o (entry_count_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o),
    .bcast_o       (bcast),
    .key_o         (key),
    .count_o       (count),
    .tok_o         (tok[0]),
    .tok_last_i    (tok[CAPACITY]),
    .head_val_i    (val[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sl_cell #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bcast_i     (bcast),
      .key_i       (key),
      .count_i     (count),
      .tok_i       (tok[i]),
      .carry_i     (carry[i]),
      .right_val_i (val[i+1]),
      .head_val_i  (val[0]),
      .tok_o       (tok[i+1]),
      .carry_o     (carry[i+1]),
      .val_o       (val[i])
    );
  end

endmodule
`default_nettype wire

// ===== sv/sl_checker.sv =====
// Port-level checks on the result stream of the sorted list table, bound to the top level.
`default_nettype none
module sl_checker
  import sl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [2:0]                    command_i,
  input wire logic [31:0]                   key_value_i,
  input wire logic                          cfg_we_i,
  input wire logic                          cfg_wdata_i,
  input wire logic                          done_o,
  input wire logic [1:0]                    status_o,
  input wire logic                          found_o,
  input wire logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  input wire logic [31:0]                   entry_value_o,
  input wire logic                          last_o
);

  localparam int CNT_W = $clog2(CAPACITY+1);

  // A dump in progress keeps the block busy and delivers one result every cycle.
  a_dump_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy) else $error("busy low with dump results pending");

  a_dump_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o) else $error("gap inside a dump");

  // The final result of a command frees the block for the next transaction.
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && last_o |-> !busy) else $error("busy after the last result");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> entry_count_o <= CNT_W'(CAPACITY)) else $error("entry count beyond capacity");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> status_o == STAT_OK && entry_value_o == '0)
    else $error("found flagged with bad status or value");

endmodule

bind sorted_list_table sl_checker #(.CAPACITY(CAPACITY)) u_sl_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted list table, with its own prediction of every result.
`default_nettype none
module testbench;
  import sl_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int STALL_LIMIT = 500;
  localparam int SETTLE      = CAPACITY + 4;

  // Codes the block treats as no-operation commands.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [CNT_W-1:0] count;
    logic [31:0]      value;
    logic             last;
  } list_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [2:0]       command_i   = CMD_PUSH;
  logic [31:0]      key_value_i = '0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             busy;
  logic             done_o;
  logic [1:0]       status_o;
  logic             found_o;
  logic [CNT_W-1:0] entry_count_o;
  logic [31:0]      entry_value_o;
  logic             last_o;

  sorted_list_table #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_value_i  (key_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .entry_count_o(entry_count_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the list and of the compare mode.
  logic [31:0]  list_keys [CAPACITY];
  int           list_len   = 0;
  logic         cmp_signed = 1'b0;
  list_result_t expected_results[$];

  int errors          = 0;
  int commands_sent   = 0;
  int results_checked = 0;
  int dumps_sent      = 0;
  int refused_inserts = 0;
  int misses          = 0;

  function automatic bit key_after(logic [31:0] a, logic [31:0] b);
    if (cmp_signed) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic int find_key(logic [31:0] key);
    int i;
    for (i = 0; i < list_len; i++)
      if (list_keys[i] == key) return i;
    return -1;
  endfunction

  // Updates the shadow list for one accepted command and queues its results.
  function automatic void predict_command(logic [2:0] cmd, logic [31:0] key);
    int pos;
    int i;
    list_result_t r;
    r = '{status: STAT_OK, found: 1'b0, count: '0, value: '0, last: 1'b1};
    pos = 0;
    commands_sent++;
    case (cmd)
      CMD_PUSH, CMD_ASC, CMD_DESC: begin
        if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
          refused_inserts++;
        end else begin
          if (cmd == CMD_ASC) begin
            while (pos < list_len && !key_after(list_keys[pos], key)) pos++;
          end else if (cmd == CMD_DESC) begin
            while (pos < list_len && !key_after(key, list_keys[pos])) pos++;
          end
          for (i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
          list_keys[pos] = key;
          list_len++;
        end
      end
      CMD_DEL: begin
        pos = find_key(key);
        if (pos < 0) begin
          r.status = STAT_NOTFOUND;
          misses++;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
          list_len--;
          r.found = 1'b1;
        end
      end
      CMD_FIND: begin
        if (find_key(key) < 0) begin
          r.status = STAT_NOTFOUND;
          misses++;
        end else begin
          r.found = 1'b1;
        end
      end
      CMD_DUMP: begin
        dumps_sent++;
        if (list_len == 0) r.status = STAT_EMPTY;
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    if (cmd == CMD_DUMP && list_len != 0) begin
      for (i = 0; i < list_len; i++) begin
        r.value = list_keys[i];
        r.last  = (i == list_len - 1);
        expected_results.push_back(r);
      end
    end else begin
      expected_results.push_back(r);
    end
  endfunction

  // Drives one command and holds it until the transaction is taken.
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] key);
    start       <= 1'b1;
    command_i   <= cmd;
    key_value_i <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_command(cmd, key);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Random sender idling, with the odd full pause until everything has come back.
  task automatic idle_between();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      pause_until_drained();
    end else if (roll < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic write_compare_mode(input logic mode);
    pause_until_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cmp_signed  = mode;
  endtask

  function automatic logic [31:0] pick_key(int pct_from_list);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < pct_from_list && list_len > 0)
      return list_keys[$urandom_range(0, list_len - 1)];
    if (roll < pct_from_list + 20) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_insert();
    case ($urandom_range(0, 2))
      0:       return CMD_PUSH;
      1:       return CMD_ASC;
      default: return CMD_DESC;
    endcase
  endfunction

  // Filling favours inserts; draining favours deletes so that the list empties again.
  function automatic logic [2:0] pick_command(bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= 95) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    if (roll >= 85) return CMD_DUMP;
    if (filling) begin
      if (roll < 55) return pick_insert();
      if (roll < 70) return CMD_DEL;
      return CMD_FIND;
    end
    if (roll < 20) return pick_insert();
    if (roll < 70) return CMD_DEL;
    return CMD_FIND;
  endfunction

  task automatic test_directed();
    send_command(CMD_DUMP, 32'hDEAD_BEEF);
    send_command(CMD_DEL,  32'h0000_0000);
    send_command(CMD_FIND, 32'hFFFF_FFFF);
    send_command(CMD_PUSH, 32'h0000_0000);
    send_command(CMD_PUSH, 32'hFFFF_FFFF);
    send_command(CMD_ASC,  32'h8000_0000);
    send_command(CMD_ASC,  32'h7FFF_FFFF);
    send_command(CMD_ASC,  32'h0000_0001);
    // An equal key goes in after the existing one.
    send_command(CMD_ASC,  32'h0000_0001);
    send_command(CMD_DESC, 32'h0000_0005);
    send_command(CMD_DESC, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 32'h0000_0002);
    send_command(CMD_DEL,  32'h0000_0001);
    send_command(CMD_DEL,  32'h1234_5678);
    send_command(CMD_SPARE_A, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_B, 32'h0000_0000);
    send_command(CMD_DUMP, 32'h0000_0000);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY) begin
      send_command(pick_insert(), pick_key(20));
      idle_between();
    end
    send_command(CMD_ASC,  32'h8000_0000);
    send_command(CMD_DESC, 32'h7FFF_FFFF);
    send_command(CMD_PUSH, $urandom);
    // Let the block go quiet before dumping the full list.
    pause_until_drained();
    send_command(CMD_DUMP, $urandom);
    send_command(CMD_FIND, pick_key(100));
    send_command(CMD_DEL,  pick_key(100));
    send_command(CMD_DESC, 32'h8000_0000);
    send_command(CMD_ASC,  32'h0000_0000);
    send_command(CMD_DUMP, $urandom);
  endtask

  task automatic test_random(input int items, input bit with_idling);
    int n;
    bit filling;
    logic [2:0] cmd;
    filling = 1'b1;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 39) filling = !filling;
      cmd = pick_command(filling);
      if (cmd == CMD_DEL || cmd == CMD_FIND) send_command(cmd, pick_key(70));
      else send_command(cmd, pick_key(30));
      if (with_idling) idle_between();
    end
  endtask

  list_result_t got_result;
  list_result_t want_result;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_result = '{status_o, found_o, entry_count_o, entry_value_o, last_o};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors < 40)
          $display("%0t: unexpected result: status %0d found %0d count %0d value %h last %0d",
                   $time, got_result.status, got_result.found, got_result.count,
                   got_result.value, got_result.last);
      end else begin
        want_result = expected_results.pop_front();
        results_checked++;
        if (got_result !== want_result) begin
          errors++;
          if (errors < 40) begin
            $display("%0t: mismatch, expected status %0d found %0d count %0d value %h last %0d",
                     $time, want_result.status, want_result.found, want_result.count,
                     want_result.value, want_result.last);
            $display("%0t:           actual status %0d found %0d count %0d value %h last %0d",
                     $time, got_result.status, got_result.found, got_result.count,
                     got_result.value, got_result.last);
          end
        end
      end
    end
  end

  // Ends the run if neither a command nor a result moves for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) stalled = 0;
      else stalled++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_compare_mode(1'b1);
    test_full_list();
    test_random(150, 1'b1);
    write_compare_mode(1'b0);
    test_random(150, 1'b1);
    write_compare_mode(1'b1);
    test_random(100, 1'b1);
    // Closing stretch sent back to back.
    test_random(100, 1'b0);
    pause_until_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d commands (%0d dumps, %0d refused inserts, %0d misses) in both compare modes.",
             commands_sent, dumps_sent, refused_inserts, misses);
    $display("Checked %0d results, %0d errors.", results_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
